// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  // queue size and derived widths
  localparam int DEPTH   = 16;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int FILL_W  = 5;
  localparam int ERR_W   = 2;
  localparam int RES_W   = 1 + 2 * VALUE_W + FILL_W + 1 + ERR_W;
  localparam int OUT_W   = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - RES_W;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] count_t;

  localparam addr_t      LAST_ADDR  = AW'(DEPTH - 1);
  localparam count_t     FULL_COUNT = CW'(DEPTH);
  localparam logic [AW:0] DEPTH_A   = (AW + 1)'(DEPTH);

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_LEFT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_RIGHT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_LEFT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_RIGHT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_rd;
    logic scan_cmp;
    logic left_rd;
    logic left_cap;
    logic right_cap;
    logic clear_lr;
    logic load_out;
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_go;
    logic scan_last;
    logic count_zero;
    logic out_free;
  } deq_status_t;

  // ring index arithmetic, both operands below DEPTH
  function automatic addr_t ring_add(addr_t base, addr_t off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  function automatic addr_t ring_dec(addr_t base);
    addr_t res;
    res = (base == '0) ? LAST_ADDR : base - 1'b1;
    return res;
  endfunction

endpackage

// ===== rtl/deq_ctrl.sv =====
module deq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  deq_pkg::deq_status_t status,
  output deq_pkg::deq_cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_EXEC      = 8'b0000_0010,
    ST_SCAN_RD   = 8'b0000_0100,
    ST_SCAN_CMP  = 8'b0000_1000,
    ST_LEFT_RD   = 8'b0001_0000,
    ST_LEFT_CAP  = 8'b0010_0000,
    ST_RIGHT_CAP = 8'b0100_0000,
    ST_RESULT    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.search_go ? ST_SCAN_RD : ST_LEFT_RD;
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_next   = status.scan_last ? ST_LEFT_RD : ST_SCAN_RD;
      end
      ST_LEFT_RD: begin
        if (status.count_zero) begin
          cmd.clear_lr = 1'b1;
          state_next   = ST_RESULT;
        end else begin
          cmd.left_rd = 1'b1;
          state_next  = ST_LEFT_CAP;
        end
      end
      ST_LEFT_CAP: begin
        cmd.left_cap = 1'b1;
        state_next   = ST_RIGHT_CAP;
      end
      ST_RIGHT_CAP: begin
        cmd.right_cap = 1'b1;
        state_next    = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/deq_dp.sv =====
module deq_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  deq_pkg::deq_cmd_t                 cmd,
  output deq_pkg::deq_status_t              status,
  input  logic [deq_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [deq_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [deq_pkg::OUT_W-1:0]         out_data
);

  logic [deq_pkg::VALUE_W-1:0] mem [deq_pkg::DEPTH];

  logic [deq_pkg::KIND_W-1:0]  kind;
  logic [deq_pkg::VALUE_W-1:0] value;
  deq_pkg::addr_t              head;
  deq_pkg::count_t             count;
  deq_pkg::addr_t              idx;
  logic                        found;
  logic [deq_pkg::ERR_W-1:0]   err;
  logic [deq_pkg::VALUE_W-1:0] left;
  logic [deq_pkg::VALUE_W-1:0] right;
  logic [deq_pkg::VALUE_W-1:0] rdata;

  deq_pkg::count_t             cnt_m1;
  deq_pkg::addr_t              rd_addr;
  deq_pkg::addr_t              wr_addr;
  logic                        wr_en;
  logic                        full;
  logic                        empty;
  logic [deq_pkg::FILL_W-1:0]  count_ext;

  assign cnt_m1    = count - 1'b1;
  assign full      = (count == deq_pkg::FULL_COUNT);
  assign empty     = (count == '0);
  assign count_ext = deq_pkg::FILL_W'(count);

  // status to controller
  assign status.search_go  = (kind == deq_pkg::KIND_SEARCH) && !empty;
  assign status.scan_last  = (deq_pkg::CW'(idx) == cnt_m1);
  assign status.count_zero = empty;
  assign status.out_free   = !out_valid || out_ready;

  // write port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = deq_pkg::ring_dec(head);
    if (cmd.exec && !full) begin
      case (kind)
        deq_pkg::KIND_PUSH_LEFT: begin
          wr_en = 1'b1;
        end
        deq_pkg::KIND_PUSH_RIGHT: begin
          wr_en   = 1'b1;
          wr_addr = deq_pkg::ring_add(head, count[deq_pkg::AW-1:0]);
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // read address select
  always_comb begin
    if (cmd.scan_rd) begin
      rd_addr = deq_pkg::ring_add(head, idx);
    end else if (cmd.left_cap) begin
      rd_addr = deq_pkg::ring_add(head, cnt_m1[deq_pkg::AW-1:0]);
    end else begin
      rd_addr = head;
    end
  end

  // cell store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    if (cmd.scan_rd || cmd.left_rd || cmd.left_cap) begin
      rdata <= mem[rd_addr];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind  <= in_kind;
      value <= in_value;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      case (kind)
        deq_pkg::KIND_PUSH_LEFT: begin
          if (!full) begin
            head  <= deq_pkg::ring_dec(head);
            count <= count + 1'b1;
          end
        end
        deq_pkg::KIND_PUSH_RIGHT: begin
          if (!full) begin
            count <= count + 1'b1;
          end
        end
        deq_pkg::KIND_POP_LEFT: begin
          if (!empty) begin
            head  <= deq_pkg::ring_add(head, deq_pkg::addr_t'(1));
            count <= cnt_m1;
          end
        end
        deq_pkg::KIND_POP_RIGHT: begin
          if (!empty) begin
            count <= cnt_m1;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // error code, search index and hit flag
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx   <= '0;
      found <= 1'b0;
      case (kind)
        deq_pkg::KIND_PUSH_LEFT, deq_pkg::KIND_PUSH_RIGHT: begin
          err <= full ? deq_pkg::ERR_FULL : deq_pkg::ERR_OK;
        end
        deq_pkg::KIND_POP_LEFT, deq_pkg::KIND_POP_RIGHT: begin
          err <= empty ? deq_pkg::ERR_EMPTY : deq_pkg::ERR_OK;
        end
        default: begin
          err <= deq_pkg::ERR_OK;
        end
      endcase
    end else if (cmd.scan_cmp) begin
      idx <= idx + 1'b1;
      if (rdata == value) begin
        found <= 1'b1;
      end
    end
  end

  // end words
  always_ff @(posedge clk) begin
    if (cmd.clear_lr) begin
      left  <= '0;
      right <= '0;
    end else begin
      if (cmd.left_cap) begin
        left <= rdata;
      end
      if (cmd.right_cap) begin
        right <= rdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {{deq_pkg::OUT_PAD{1'b0}}, err, empty,
                   count_ext, right, left, found};
    end
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH (16) signed 32-bit words, one operation per
// input transfer (s_tuser: 0 push left, 1 push right, 2 pop left, 3 pop right,
// 4 search for s_tdata) and one result transfer per operation carrying the hit
// flag, the leftmost and rightmost words (zero when empty), the fill count, an
// empty flag and an error code (1 push on full, dropped; 2 pop on empty). Items
// are handled one at a time: a push or pop runs execute, a left-end read and the
// left and right word captures, the reads skipped when the queue is left empty,
// and a search adds a read and a compare step per stored entry, as every cell
// access goes through the single registered read port of the cell store. A
// finished result waits in the output register while the next operation is
// accepted. Cells never written hold no defined value but are never reported.
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] value
  input  logic [deq_pkg::VALUE_W-1:0]       s_tdata,
  // [2:0] kind
  input  logic [deq_pkg::KIND_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] found, [32:1] left_value, [64:33] right_value, [69:65] fill_count,
  // [70] is_empty, [72:71] error_code, [79:73] zero
  output logic [deq_pkg::OUT_W-1:0]         m_tdata
);

  deq_pkg::deq_cmd_t    cmd;
  deq_pkg::deq_status_t status;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  deq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_kind   (s_tuser),
    .in_value  (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ===== rtl/deq_checker.sv =====
module deq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [deq_pkg::OUT_W-1:0]   m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one operation at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an operation is in progress");

  // empty queue reports zero fill and zero end words
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[70] |->
      (m_tdata[69:65] == '0) && (m_tdata[64:1] == '0))
    else $error("empty result with stale contents");

  // a search hit never comes with an error
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[72:71] == deq_pkg::ERR_OK) && !m_tdata[70])
    else $error("hit reported with error or on empty queue");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/double_ended_queue_checker.sv =====
`timescale 1ns / 1ps

// watches both streams of the deque, keeps its own copy of the ring and
// compares every result transfer against the predicted answer
module double_ended_queue_checker
  import deq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [VALUE_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]   s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OUT_W-1:0]    m_tdata,
  output int                  mismatches,
  output int                  pending
);

  // result layout, highest field first so it maps straight onto m_tdata
  typedef struct packed {
    logic [ERR_W-1:0]          error_code;
    logic                      is_empty;
    logic [FILL_W-1:0]         fill_count;
    logic signed [VALUE_W-1:0] right_value;
    logic signed [VALUE_W-1:0] left_value;
    logic                      found;
  } deque_answer_t;

  // shadow copy of the ring
  logic [VALUE_W-1:0] ring_cells [DEPTH];
  int                 ring_head;
  int                 ring_entries;

  deque_answer_t      pending_answers[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: deque result error: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%h want 0x%h", name, got, want));
    end
  endtask

  // applies one operation to the shadow ring and returns what the block must answer
  function automatic deque_answer_t predict_answer(input logic [KIND_W-1:0] kind,
                                                   input logic [VALUE_W-1:0] word);
    deque_answer_t ans;
    int            i;
    ans = '0;
    ans.error_code = ERR_OK;
    case (kind)
      KIND_PUSH_LEFT: begin
        if (ring_entries >= DEPTH) begin
          ans.error_code = ERR_FULL;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_cells[ring_head] = word;
          ring_entries++;
        end
      end
      KIND_PUSH_RIGHT: begin
        if (ring_entries >= DEPTH) begin
          ans.error_code = ERR_FULL;
        end else begin
          ring_cells[(ring_head + ring_entries) % DEPTH] = word;
          ring_entries++;
        end
      end
      KIND_POP_LEFT: begin
        if (ring_entries == 0) begin
          ans.error_code = ERR_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_entries--;
        end
      end
      KIND_POP_RIGHT: begin
        if (ring_entries == 0) begin
          ans.error_code = ERR_EMPTY;
        end else begin
          ring_entries--;
        end
      end
      KIND_SEARCH: begin
        for (i = 0; i < ring_entries; i++) begin
          if (ring_cells[(ring_head + i) % DEPTH] == word) begin
            ans.found = 1'b1;
          end
        end
      end
      default: begin
        // unused kinds leave everything alone
      end
    endcase
    // end words read back only from counted entries
    if (ring_entries == 0) begin
      ans.is_empty = 1'b1;
    end else begin
      ans.left_value  = ring_cells[ring_head];
      ans.right_value = ring_cells[(ring_head + ring_entries - 1) % DEPTH];
    end
    ans.fill_count = FILL_W'(ring_entries);
    return ans;
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    deque_answer_t got;
    deque_answer_t want;
    if (rst) begin
      ring_head    = 0;
      ring_entries = 0;
      pending_answers.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        pending_answers.push_back(predict_answer(s_tuser, s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got = deque_answer_t'(m_tdata[RES_W-1:0]);
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing outstanding, data 0x%h",
                                    m_tdata));
        end else begin
          want = pending_answers.pop_front();
          compare_field("found", VALUE_W'(got.found), VALUE_W'(want.found));
          compare_field("left_value", got.left_value, want.left_value);
          compare_field("right_value", got.right_value, want.right_value);
          compare_field("fill_count", VALUE_W'(got.fill_count), VALUE_W'(want.fill_count));
          compare_field("is_empty", VALUE_W'(got.is_empty), VALUE_W'(want.is_empty));
          compare_field("error_code", VALUE_W'(got.error_code), VALUE_W'(want.error_code));
          compare_field("pad bits", VALUE_W'(m_tdata[OUT_W-1:RES_W]), '0);
        end
      end
    end
    pending = pending_answers.size();
  end

endmodule

// ===== tb/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int RANDOM_TARGET = 950;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_BURST    = 12;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SEARCH} op_mix_t;
  typedef enum int {RX_STREAM, RX_SPARSE, RX_DENSE, RX_PERIODIC} rx_mode_t;

  logic               clk;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata  = '0;
  logic [KIND_W-1:0]  s_tuser  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;

  int                 mismatches;
  int                 pending;

  // sender bookkeeping
  int                 ops_sent      = 0;
  int                 burst_left    = 0;
  bit                 gaps_on       = 1'b1;
  int                 hold_requests = 0;
  int                 holds_done    = 0;
  logic [VALUE_W-1:0] recent_words [8];

  double_ended_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  double_ended_queue_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: stall pattern changes every stretch, long hold on request
  initial begin
    rx_mode_t mode;
    int       stretch;
    int       tick;
    mode    = RX_STREAM;
    stretch = 0;
    tick    = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_t'($urandom_range(0, 3));
          stretch = $urandom_range(50, 300);
        end
        stretch--;
        tick++;
        case (mode)
          RX_STREAM:   m_tready <= 1'b1;
          RX_SPARSE:   m_tready <= ($urandom_range(0, 99) < 30);
          RX_DENSE:    m_tready <= ($urandom_range(0, 99) < 80);
          default:     m_tready <= ((tick % 4) != 0);
        endcase
      end
    end
  end

  // one transfer into the deque, then possibly a gap when the burst runs out
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    ops_sent++;
    if (kind == KIND_PUSH_LEFT || kind == KIND_PUSH_RIGHT) begin
      recent_words[$urandom_range(0, 7)] = word;
    end
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      burst_left--;
    end
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(input op_mix_t mix);
    int roll;
    int push_pct;
    int pop_pct;
    int search_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin push_pct = 70; pop_pct = 15; search_pct = 12; end
      MIX_DRAIN: begin push_pct = 25; pop_pct = 55; search_pct = 16; end
      MIX_EVEN:  begin push_pct = 40; pop_pct = 35; search_pct = 20; end
      default:   begin push_pct = 25; pop_pct = 15; search_pct = 57; end
    endcase
    if (roll < push_pct) begin
      return $urandom_range(0, 1) ? KIND_PUSH_LEFT : KIND_PUSH_RIGHT;
    end else if (roll < push_pct + pop_pct) begin
      return $urandom_range(0, 1) ? KIND_POP_LEFT : KIND_POP_RIGHT;
    end else if (roll < push_pct + pop_pct + search_pct) begin
      return KIND_SEARCH;
    end
    // codes above search are unused
    return KIND_SEARCH + KIND_W'($urandom_range(1, 3));
  endfunction

  // mix of stored words (search hits), near-duplicates, extremes and noise
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return recent_words[$urandom_range(0, 7)];
      3:       return VALUE_W'($signed($urandom_range(0, 4)) - 2);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return '1;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    op_mix_t mix;
    int      mix_len;
    int      k;
    bit      drained;
    drained = 1'b0;
    foreach (recent_words[i]) recent_words[i] = '0;
    do @(posedge clk); while (rst);

    // empty queue corner cases and the unused kinds
    send_op(KIND_POP_LEFT, 32'h1234_5678);
    send_op(KIND_POP_RIGHT, '1);
    send_op(KIND_SEARCH, '0);
    send_op(KIND_SEARCH + KIND_W'(1), '1);
    send_op(KIND_SEARCH + KIND_W'(2), 32'h8000_0000);
    send_op(KIND_SEARCH + KIND_W'(3), 32'h7fff_ffff);
    // extremes at both ends, hits and a miss
    send_op(KIND_PUSH_RIGHT, 32'h7fff_ffff);
    send_op(KIND_PUSH_LEFT, 32'h8000_0000);
    send_op(KIND_PUSH_RIGHT, '1);
    send_op(KIND_PUSH_LEFT, '0);
    send_op(KIND_SEARCH, 32'h7fff_ffff);
    send_op(KIND_SEARCH, 32'h8000_0000);
    send_op(KIND_SEARCH, '0);
    send_op(KIND_SEARCH, 32'h0000_3039);
    send_op(KIND_SEARCH + KIND_W'(3), '0);
    send_op(KIND_POP_RIGHT, '0);
    send_op(KIND_SEARCH, '1);
    send_op(KIND_POP_LEFT, '1);
    send_op(KIND_POP_LEFT, '0);
    send_op(KIND_POP_RIGHT, '0);
    send_op(KIND_POP_LEFT, '0);
    send_op(KIND_PUSH_LEFT, 32'h0000_0001);
    send_op(KIND_POP_RIGHT, '0);

    // random phases, fill-heavy ones reach the full queue
    ops_sent = 0;
    while (ops_sent < RANDOM_TARGET) begin
      mix     = op_mix_t'($urandom_range(0, 3));
      mix_len = $urandom_range(15, 60);
      for (k = 0; k < mix_len; k++) begin
        send_op(pick_kind(mix), pick_word());
      end

      // long receiver hold while the sender keeps offering
      if ((ops_sent > 300 && hold_requests == 0) || (ops_sent > 650 && hold_requests == 1)) begin
        hold_requests++;
        gaps_on = 1'b0;
        repeat (HOLD_BURST) send_op(pick_kind(MIX_FILL), pick_word());
        gaps_on = 1'b1;
      end

      // let every result come back before carrying on
      if (ops_sent > 500 && !drained) begin
        drained = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
tb/double_ended_queue_checker.sv
tb/double_ended_queue_tb.sv
